@@ rtl/core/wta_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Winner-takes-all hit adder package
// Shared constants, word types and per-track accumulator type.
// ----------------------------------------------------------------------------
package wta_pkg;

    // Tracks 1 .. NUM_TRACKS are accumulated.
    localparam int NUM_TRACKS = 2;
    localparam int TRK_IDX_W  = (NUM_TRACKS > 1) ? $clog2(NUM_TRACKS) : 1;

    // Function codes of an input word.
    localparam logic FUNC_HIT   = 1'b0;
    localparam logic FUNC_FLUSH = 1'b1;

    localparam logic [31:0] ENERGY_MAX = 32'hFFFF_FFFF;

    typedef struct packed {
        logic               func;
        logic [30:0]        event_id;
        logic [3:0]         track_id;
        logic               is_gamma;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic [47:0]        hit_time;
        logic [23:0]        edep;
        logic [31:0]        volume_id;
    } t_hit;

    typedef struct packed {
        logic [30:0]        single_event;
        logic [1:0]         single_track;
        logic signed [31:0] single_x;
        logic signed [31:0] single_y;
        logic signed [31:0] single_z;
        logic [47:0]        single_time;
        logic [31:0]        energy_sum;
        logic [31:0]        single_volume;
        logic               coincidence;
        logic               last;
    } t_single;

    // Running state of one track within the open event.
    typedef struct packed {
        logic               seen;
        logic [31:0]        total;
        logic [23:0]        peak_e;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic [47:0]        hit_time;
        logic [31:0]        volume;
    } t_acc;

endpackage

@@ rtl/core/wta_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Winner-takes-all hit adder stream interfaces
// Valid/ready channels for hit words and single words.
// ----------------------------------------------------------------------------
interface wta_hit_if;
    logic          valid;
    logic          ready;
    wta_pkg::t_hit data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface wta_single_if;
    logic             valid;
    logic             ready;
    wta_pkg::t_single data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/core/winner_takes_all_hit_adder.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Winner-takes-all hit adder
// Sums gamma energy per track within an event, keeps the largest deposit and
// emits one single per track with nonzero energy when the event closes.
// ----------------------------------------------------------------------------
//
//  Channel    Direction  Word      Notes
//  i_hit      in         t_hit     hit or flush request, grouped by event
//  o_single   out        t_single  up to NUM_TRACKS singles per closed event
//
// A hit word is taken in every cycle while the snapshot bank is free; its
// compare and saturating add finish in the cycle it is accepted, into the
// per-track accumulator registers. Closing an event copies the accumulators
// into a snapshot bank in that same cycle; it drains one single per cycle
// through the output register, so a close holds off input until its last
// single is loaded. The output register lets a new word be accepted while a
// single waits. Reset (i_rst_n low at a rising edge) closes nothing and clears
// flags and sums. Backpressure on o_single stalls the drain, then i_hit.
module winner_takes_all_hit_adder (
    input  logic         i_clk,
    input  logic         i_rst_n,
    wta_hit_if.sink      i_hit,
    wta_single_if.source o_single
);
    import wta_pkg::*;

    // Open-event state.
    logic        r_event_open;
    logic [30:0] r_open_event;
    t_acc        r_acc [NUM_TRACKS];
    t_acc        n_acc [NUM_TRACKS];

    // Snapshot of a closed event, waiting to be sent.
    t_acc                  r_snap [NUM_TRACKS];
    logic [30:0]           r_snap_event;
    logic                  r_snap_coinc;
    logic [NUM_TRACKS-1:0] r_pend;
    logic [NUM_TRACKS-1:0] n_pend_new;

    // Output register.
    logic    r_out_valid;
    t_single r_out;

    logic [TRK_IDX_W-1:0]  w_sel;
    logic [NUM_TRACKS-1:0] w_take;
    logic [NUM_TRACKS-1:0] w_pend_rest;
    logic                  w_out_load;
    logic                  w_accept;
    logic                  w_is_flush;
    logic                  w_close;
    logic                  w_coinc;

    // Pick the lowest pending track of the snapshot; load it when the
    // output register is empty or being emptied.
    always_comb begin
        w_sel = '0;
        for (int t = NUM_TRACKS - 1; t >= 0; t--) begin
            if (r_pend[t]) begin
                w_sel = TRK_IDX_W'(t);
            end
        end
        w_out_load  = (r_pend != '0) && (!r_out_valid || o_single.ready);
        w_take      = w_out_load ? (NUM_TRACKS'(1) << w_sel) : '0;
        w_pend_rest = r_pend & ~w_take;
    end

    // A word is taken only when the snapshot bank is free by the next edge,
    // since a closing word refills it.
    assign i_hit.ready = (w_pend_rest == '0);
    assign w_accept    = i_hit.valid && i_hit.ready;

    assign w_is_flush = (i_hit.data.func == FUNC_FLUSH);
    assign w_close    = r_event_open &&
                        (w_is_flush || (i_hit.data.event_id != r_open_event));

    // Next accumulator contents: start from a cleared bank when the event
    // closes, then fold in a gamma hit of a tracked track.
    always_comb begin
        logic [32:0] sum;
        t_acc        base;
        sum  = '0;
        base = '0;
        w_coinc = 1'b1;
        for (int t = 0; t < NUM_TRACKS; t++) begin
            w_coinc       = w_coinc & r_acc[t].seen;
            n_pend_new[t] = r_acc[t].seen && (r_acc[t].total != '0);
            base = w_close ? t_acc'('0) : r_acc[t];
            if (!w_is_flush && i_hit.data.is_gamma &&
                    (i_hit.data.track_id == 4'(t + 1))) begin
                sum = {1'b0, base.total} + {9'd0, i_hit.data.edep};
                base.total = sum[32] ? ENERGY_MAX : sum[31:0];
                // Ties keep the earlier hit.
                if (i_hit.data.edep > base.peak_e) begin
                    base.peak_e   = i_hit.data.edep;
                    base.x        = i_hit.data.pos_x;
                    base.y        = i_hit.data.pos_y;
                    base.z        = i_hit.data.pos_z;
                    base.hit_time = i_hit.data.hit_time;
                    base.volume   = i_hit.data.volume_id;
                end
                base.seen = 1'b1;
            end
            n_acc[t] = base;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_event_open <= 1'b0;
            r_open_event <= '0;
            for (int t = 0; t < NUM_TRACKS; t++) begin
                r_acc[t].seen   <= 1'b0;
                r_acc[t].total  <= '0;
                r_acc[t].peak_e <= '0;
            end
        end else if (w_accept) begin
            r_event_open <= !w_is_flush;
            if (!w_is_flush && (w_close || !r_event_open)) begin
                r_open_event <= i_hit.data.event_id;
            end
            for (int t = 0; t < NUM_TRACKS; t++) begin
                r_acc[t] <= n_acc[t];
            end
        end
    end

    // Snapshot bank: payload needs no reset, the pending bits do.
    always_ff @(posedge i_clk) begin
        if (w_accept && w_close) begin
            r_snap       <= r_acc;
            r_snap_event <= r_open_event;
            r_snap_coinc <= w_coinc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else begin
            r_pend <= w_pend_rest | ((w_accept && w_close) ? n_pend_new : '0);
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_single.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out.single_event  <= r_snap_event;
            r_out.single_track  <= 2'({1'b0, w_sel} + 1'b1);
            r_out.single_x      <= r_snap[w_sel].x;
            r_out.single_y      <= r_snap[w_sel].y;
            r_out.single_z      <= r_snap[w_sel].z;
            r_out.single_time   <= r_snap[w_sel].hit_time;
            r_out.energy_sum    <= r_snap[w_sel].total;
            r_out.single_volume <= r_snap[w_sel].volume;
            r_out.coincidence   <= r_snap_coinc;
            r_out.last          <= (w_pend_rest == '0);
        end
    end

    assign o_single.valid = r_out_valid;
    assign o_single.data  = r_out;

endmodule

@@ rtl/core/wta_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Winner-takes-all hit adder checker
// Port-level assertions on the hit adder, attached by a bind statement.
// ----------------------------------------------------------------------------
module wta_checker (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_hit_valid,
    input logic             i_hit_ready,
    input logic             i_out_valid,
    input logic             i_out_ready,
    input wta_pkg::t_single i_out_data
);
    import wta_pkg::*;

    // A waiting single is not withdrawn.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("single withdrawn while stalled");

    // A single never names track zero.
    a_track_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_data.single_track != 2'd0))
        else $error("single with track zero");

    // While a non-last single is stalled, the rest of its event blocks input.
    a_burst_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_data.last && !i_out_ready |-> !(i_hit_valid && i_hit_ready))
        else $error("input taken during a stalled burst");

    // The single after a non-last one follows at once, same event, later track.
    a_burst_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && !i_out_data.last |=>
            i_out_valid &&
            (i_out_data.single_event == $past(i_out_data.single_event)) &&
            (i_out_data.single_track > $past(i_out_data.single_track)))
        else $error("burst broken");

endmodule

bind winner_takes_all_hit_adder wta_checker u_wta_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_hit_valid (i_hit.valid),
    .i_hit_ready (i_hit.ready),
    .i_out_valid (o_single.valid),
    .i_out_ready (o_single.ready),
    .i_out_data  (o_single.data)
);

@@ bench/tb_winner_takes_all_hit_adder.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Winner-takes-all hit adder testbench
// Drives hit and flush words into the block and checks every emitted single
// against a behavioral scoreboard. It covers directed corner cases, energy
// saturation, a long output hold-off and long random event streams under
// varying input gaps and output backpressure.
// ----------------------------------------------------------------------------
module tb_winner_takes_all_hit_adder;
    import wta_pkg::*;

    // Longest stretch without any accepted word before the run is declared hung.
    localparam int WATCHDOG_LIMIT = 2000;
    // Cycles the receiver refuses singles during the hold-off test.
    localparam int HOLD_CYCLES    = 300;
    // Quiet cycles after the last single, to catch stray output.
    localparam int SETTLE_CYCLES  = 20;

    typedef enum {TX_STREAM, TX_BURSTY} t_tx_mode;
    typedef enum {RX_ALWAYS, RX_RANDOM, RX_PATTERN} t_rx_mode;

    logic clk;
    logic rst_n;

    wta_hit_if    hit_ch();
    wta_single_if single_ch();

    winner_takes_all_hit_adder DUT (
        .i_clk    (clk),
        .i_rst_n  (rst_n),
        .i_hit    (hit_ch.sink),
        .o_single (single_ch.source)
    );

    // ------------------------------------------------------------------------
    // Scoreboard state: a shadow of the open event and the singles still owed
    // by the block, oldest first.
    // ------------------------------------------------------------------------
    logic        event_is_open;
    logic [30:0] open_event_no;
    t_acc        track_acc[NUM_TRACKS];
    t_single     expected_singles[$];

    int error_count;

    // Stimulus shaping shared between the test tasks and the channel drivers.
    t_tx_mode    tx_mode;
    t_rx_mode    rx_mode;
    int          burst_left;
    int          hold_requests;
    int          hold_served    = 0;
    int          hold_left      = 0;
    logic [7:0]  rx_pattern     = 8'hA5;
    logic [2:0]  rx_pattern_idx = 3'd0;
    logic [30:0] last_event_no;
    logic [30:0] older_event_no;
    int          idle_cycles    = 0;
    t_single     got_single;
    t_single     want_single;

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Failure reporting. Every mismatch prints one line and is counted; the
    // run carries on so that later problems are still seen.
    // ------------------------------------------------------------------------
    task automatic report_error(input string what);
        $display("ERROR at %0t ns: %s", $time, what);
        error_count++;
    endtask

    task automatic check_field(input string name, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want) begin
            report_error($sformatf("%s: got 0x%0h, expected 0x%0h", name, got, want));
        end
    endtask

    // ------------------------------------------------------------------------
    // Behavioral prediction
    // ------------------------------------------------------------------------

    // Closing an event emits one single per track that saw a gamma and has a
    // nonzero sum, lowest track first. The coincidence flag needs every track
    // to have seen a gamma, even one that deposited nothing. The final single
    // of the close carries the last flag.
    function automatic void close_open_event();
        t_single s;
        t_single batch[$];
        logic    coinc;
        int      k;
        coinc = 1'b1;
        for (k = 0; k < NUM_TRACKS; k++) begin
            if (!track_acc[k].seen) coinc = 1'b0;
        end
        for (k = 0; k < NUM_TRACKS; k++) begin
            if (track_acc[k].seen && track_acc[k].total != 32'd0) begin
                s.single_event  = open_event_no;
                s.single_track  = 2'(k + 1);
                s.single_x      = track_acc[k].x;
                s.single_y      = track_acc[k].y;
                s.single_z      = track_acc[k].z;
                s.single_time   = track_acc[k].hit_time;
                s.energy_sum    = track_acc[k].total;
                s.single_volume = track_acc[k].volume;
                s.coincidence   = coinc;
                s.last          = 1'b0;
                batch.push_back(s);
            end
        end
        if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
        foreach (batch[b]) expected_singles.push_back(batch[b]);
        for (k = 0; k < NUM_TRACKS; k++) track_acc[k] = '0;
        event_is_open = 1'b0;
    endfunction

    // Applies one accepted word to the shadow state and queues the singles it
    // causes.
    function automatic void predict_singles(input t_hit w);
        int          idx;
        logic [32:0] sum;
        if (w.func == FUNC_FLUSH) begin
            // A flush with nothing open is ignored, whatever its other fields.
            if (event_is_open) close_open_event();
            return;
        end
        // A different event number closes the open event, even if that number
        // was seen before.
        if (event_is_open && w.event_id != open_event_no) close_open_event();
        if (!event_is_open) begin
            event_is_open = 1'b1;
            open_event_no = w.event_id;
        end
        // Non-gamma hits and hits of untracked tracks only keep the event open.
        if (w.is_gamma && w.track_id >= 1 && w.track_id <= NUM_TRACKS) begin
            idx = int'(w.track_id) - 1;
            sum = {1'b0, track_acc[idx].total} + {9'd0, w.edep};
            track_acc[idx].total = sum[32] ? ENERGY_MAX : sum[31:0];
            // Strictly greater: on a tie the earlier deposit stays, and a zero
            // deposit can never become the peak.
            if (w.edep > track_acc[idx].peak_e) begin
                track_acc[idx].peak_e   = w.edep;
                track_acc[idx].x        = w.pos_x;
                track_acc[idx].y        = w.pos_y;
                track_acc[idx].z        = w.pos_z;
                track_acc[idx].hit_time = w.hit_time;
                track_acc[idx].volume   = w.volume_id;
            end
            track_acc[idx].seen = 1'b1;
        end
    endfunction

    // ------------------------------------------------------------------------
    // Word builders
    // ------------------------------------------------------------------------
    function automatic t_hit make_hit(input logic [30:0] ev, input logic [3:0] trk,
                                      input logic gamma, input logic [23:0] e);
        t_hit h;
        h.func      = FUNC_HIT;
        h.event_id  = ev;
        h.track_id  = trk;
        h.is_gamma  = gamma;
        h.pos_x     = $urandom;
        h.pos_y     = $urandom;
        h.pos_z     = $urandom;
        h.hit_time  = 48'({$urandom, $urandom});
        h.edep      = e;
        h.volume_id = $urandom;
        return h;
    endfunction

    // The remaining fields of a flush are random; the block must ignore them.
    function automatic t_hit flush_word();
        t_hit h;
        h = make_hit(31'($urandom), 4'($urandom), 1'($urandom), 24'($urandom));
        h.func = FUNC_FLUSH;
        return h;
    endfunction

    // Mostly tracks 1 and 2, with some untracked numbers mixed in.
    function automatic logic [3:0] rand_track();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4) return 4'd1;
        if (r < 8) return 4'd2;
        return 4'($urandom_range(0, 15));
    endfunction

    // Small energies make ties likely; full-scale ones exercise the adder.
    function automatic logic [23:0] rand_edep();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 24'd0;
        if (r == 1) return 24'hFF_FFFF;
        if (r < 6)  return 24'($urandom_range(0, 63));
        return 24'($urandom_range(0, 24'hFF_FFFF));
    endfunction

    // Usually the next event number; sometimes a jump, an earlier number
    // coming back, or one of the extremes.
    function automatic logic [30:0] pick_event_no();
        logic [30:0] ev;
        int          r;
        r = $urandom_range(0, 19);
        if (r < 14)      ev = last_event_no + 31'd1;
        else if (r < 17) ev = 31'($urandom);
        else if (r < 19) ev = older_event_no;
        else             ev = $urandom_range(0, 1) ? 31'h7FFF_FFFF : 31'd0;
        older_event_no = last_event_no;
        last_event_no  = ev;
        return ev;
    endfunction

    // ------------------------------------------------------------------------
    // Input side. A word is offered until the block takes it; in bursty mode
    // the sender goes quiet between bursts. Within a burst, valid stays high
    // from word to word so it is never dropped and raised in one step.
    // ------------------------------------------------------------------------
    task automatic send_word(input t_hit w);
        int gap;
        if (tx_mode == TX_BURSTY) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 12);
                gap        = $urandom_range(1, 6);
                hit_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left--;
        end
        hit_ch.valid <= 1'b1;
        hit_ch.data  <= w;
        @(posedge clk);
        while (hit_ch.ready !== 1'b1) @(posedge clk);
        predict_singles(w);
    endtask

    // The sender stops and waits until every owed single has come out.
    task automatic drain_singles();
        hit_ch.valid <= 1'b0;
        @(posedge clk);
        while (expected_singles.size() != 0) @(posedge clk);
    endtask

    // Sends well-formed events of random content until about n_items words
    // have gone in, with an occasional flush between events.
    task automatic run_event_stream(input int n_items);
        int          sent;
        int          nhits;
        int          k;
        logic [30:0] ev;
        sent = 0;
        while (sent < n_items) begin
            ev    = pick_event_no();
            nhits = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24)
                                                : $urandom_range(1, 6);
            for (k = 0; k < nhits; k++) begin
                send_word(make_hit(ev, rand_track(), $urandom_range(0, 7) != 0,
                                   rand_edep()));
                sent++;
            end
            if ($urandom_range(0, 5) == 0) begin
                send_word(flush_word());
                sent++;
                // A second flush right away finds no open event.
                if ($urandom_range(0, 3) == 0) send_word(flush_word());
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Output side. The receiver is always ready, ready at random, or follows
    // a rotating 8-bit mask. A hold-off request makes it refuse every single
    // until the hold-off countdown kept here runs out.
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        if (!rst_n) begin
            single_ch.ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left       <= hold_left - 1;
            single_ch.ready <= 1'b0;
        end else if (hold_served != hold_requests) begin
            hold_served     <= hold_served + 1;
            hold_left       <= HOLD_CYCLES - 1;
            single_ch.ready <= 1'b0;
        end else begin
            case (rx_mode)
                RX_ALWAYS: begin
                    single_ch.ready <= 1'b1;
                end
                RX_RANDOM: begin
                    single_ch.ready <= ($urandom_range(0, 99) < 60);
                end
                default: begin
                    single_ch.ready <= rx_pattern[rx_pattern_idx];
                    rx_pattern_idx  <= rx_pattern_idx + 3'd1;
                    // A fresh mask every lap; bit 0 keeps it from going dead.
                    if (rx_pattern_idx == 3'd7) rx_pattern <= 8'($urandom) | 8'h01;
                end
            endcase
        end
    end

    // Every single taken is compared field by field with the oldest one owed.
    always @(posedge clk) begin
        if (rst_n && single_ch.valid && single_ch.ready) begin
            got_single = single_ch.data;
            if (expected_singles.size() == 0) begin
                report_error($sformatf("unexpected single: event 0x%0h track %0d",
                                       got_single.single_event, got_single.single_track));
            end else begin
                want_single = expected_singles.pop_front();
                check_field("single_event", got_single.single_event, want_single.single_event);
                check_field("single_track", got_single.single_track, want_single.single_track);
                check_field("single_x", got_single.single_x, want_single.single_x);
                check_field("single_y", got_single.single_y, want_single.single_y);
                check_field("single_z", got_single.single_z, want_single.single_z);
                check_field("single_time", got_single.single_time, want_single.single_time);
                check_field("energy_sum", got_single.energy_sum, want_single.energy_sum);
                check_field("single_volume", got_single.single_volume,
                            want_single.single_volume);
                check_field("coincidence", got_single.coincidence, want_single.coincidence);
                check_field("last", got_single.last, want_single.last);
            end
        end
    end

    // Watchdog: ends the run when no word moves on either channel for too long.
    always @(posedge clk) begin
        if (!rst_n || (hit_ch.valid && hit_ch.ready) ||
            (single_ch.valid && single_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("ERROR at %0t ns: no word moved for %0d cycles", $time, idle_cycles);
            $display("Test completed with failures");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Both tracks hit at the extremes of every field: coincident singles, then
    // the largest event number closed by a flush.
    task automatic test_extreme_fields();
        t_hit h;
        h = make_hit(31'd0, 4'd1, 1'b1, 24'hFF_FFFF);
        h.pos_x     = 32'sh8000_0000;
        h.pos_y     = 32'sh7FFF_FFFF;
        h.pos_z     = -32'sd1;
        h.hit_time  = 48'hFFFF_FFFF_FFFF;
        h.volume_id = 32'hFFFF_FFFF;
        send_word(h);
        h = make_hit(31'd0, 4'd2, 1'b1, 24'd1);
        h.pos_x     = 32'sd0;
        h.pos_y     = 32'sd0;
        h.pos_z     = 32'sd0;
        h.hit_time  = 48'd0;
        h.volume_id = 32'd0;
        send_word(h);
        send_word(make_hit(31'h7FFF_FFFF, 4'd2, 1'b1, 24'd100));
        send_word(flush_word());
        drain_singles();
    endtask

    task automatic test_special_cases();
        // Flush while nothing is open gives no output.
        send_word(flush_word());

        // Non-gamma and untracked hits open an event but add nothing, so the
        // flush that closes it emits no single.
        send_word(make_hit(31'd5, 4'd1, 1'b0, 24'd500));
        send_word(make_hit(31'd5, 4'd0, 1'b1, 24'd7));
        send_word(make_hit(31'd5, 4'd3, 1'b1, 24'd9));
        send_word(make_hit(31'd5, 4'd15, 1'b1, 24'd11));
        send_word(flush_word());

        // A zero-energy gamma marks track 1 as seen: no single for it, but
        // the single of track 2 is flagged coincident.
        send_word(make_hit(31'd6, 4'd1, 1'b1, 24'd0));
        send_word(make_hit(31'd6, 4'd2, 1'b1, 24'd10));
        send_word(flush_word());

        // Equal deposits: the first one stays the peak.
        send_word(make_hit(31'd7, 4'd1, 1'b1, 24'd50));
        send_word(make_hit(31'd7, 4'd1, 1'b1, 24'd50));
        send_word(make_hit(31'd7, 4'd1, 1'b1, 24'd20));

        // Event 8 comes back after event 9 and is closed as a separate event.
        send_word(make_hit(31'd8, 4'd1, 1'b1, 24'd30));
        send_word(make_hit(31'd9, 4'd2, 1'b1, 24'd40));
        send_word(make_hit(31'd8, 4'd1, 1'b1, 24'd60));
        send_word(flush_word());
        drain_singles();
    endtask

    // 257 full-scale deposits overflow 32 bits; track 1 gets 262 of them here,
    // so its sum must stick at the maximum while more hits keep arriving.
    task automatic test_energy_saturation();
        int k;
        tx_mode = TX_BURSTY;
        rx_mode = RX_RANDOM;
        for (k = 0; k < 280; k++) begin
            send_word(make_hit(31'h0012_3456, (k % 16 == 5) ? 4'd2 : 4'd1, 1'b1,
                               (k % 16 == 5) ? 24'($urandom) : 24'hFF_FFFF));
        end
        send_word(make_hit(31'h0012_3457, 4'd2, 1'b1, 24'd1));
        send_word(flush_word());
        drain_singles();
    endtask

    // The receiver holds off for a long stretch while the sender keeps
    // offering short two-track events; the block must fill and stall its input
    // without losing or reordering singles.
    task automatic test_output_hold();
        int k;
        tx_mode = TX_STREAM;
        rx_mode = RX_ALWAYS;
        hold_requests <= hold_requests + 1;
        for (k = 0; k < 40; k++) begin
            send_word(make_hit(31'(1000 + k), 4'd1, 1'b1, rand_edep()));
            send_word(make_hit(31'(1000 + k), 4'd2, 1'b1, rand_edep()));
        end
        send_word(flush_word());
        drain_singles();
    endtask

    // Long random event streams, one phase per combination of input gaps and
    // output stalls, including a phase with no idling on either side. The
    // sender pauses until all singles are out between phases.
    task automatic test_random_phases();
        int phase;
        for (phase = 0; phase < 6; phase++) begin
            case (phase)
                0: begin tx_mode = TX_STREAM; rx_mode = RX_ALWAYS;  end
                1: begin tx_mode = TX_BURSTY; rx_mode = RX_RANDOM;  end
                2: begin tx_mode = TX_STREAM; rx_mode = RX_PATTERN; end
                3: begin tx_mode = TX_BURSTY; rx_mode = RX_ALWAYS;  end
                4: begin tx_mode = TX_BURSTY; rx_mode = RX_PATTERN; end
                default: begin tx_mode = TX_STREAM; rx_mode = RX_RANDOM; end
            endcase
            run_event_stream(220);
            send_word(flush_word());
            drain_singles();
        end
    endtask

    // Unstructured words: every field random, flushes at random, event
    // numbers drawn so that some hits still group together.
    task automatic test_noise_words();
        t_hit h;
        int   k;
        tx_mode = TX_BURSTY;
        rx_mode = RX_RANDOM;
        for (k = 0; k < 150; k++) begin
            h = make_hit($urandom_range(0, 1) ? last_event_no : 31'($urandom),
                         4'($urandom), 1'($urandom), 24'($urandom));
            if ($urandom_range(0, 9) == 0) h.func = FUNC_FLUSH;
            last_event_no = h.event_id;
            send_word(h);
        end
        send_word(flush_word());
        drain_singles();
    endtask

    initial begin
        // The sender side is known from time zero; the receiver process
        // drives ready from the first clock edge on.
        rst_n           <= 1'b0;
        hit_ch.valid    <= 1'b0;
        hit_ch.data     <= '0;

        event_is_open  = 1'b0;
        open_event_no  = '0;
        foreach (track_acc[k]) track_acc[k] = '0;
        error_count    = 0;
        tx_mode        = TX_STREAM;
        rx_mode        = RX_ALWAYS;
        burst_left     = 0;
        hold_requests  = 0;
        last_event_no  = 31'd100;
        older_event_no = 31'd99;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        test_extreme_fields();
        test_special_cases();
        test_energy_saturation();
        test_output_hold();
        test_random_phases();
        test_noise_words();

        // Nothing more is owed; give the block time to show any stray single.
        drain_singles();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (expected_singles.size() != 0) begin
            report_error($sformatf("%0d singles never arrived", expected_singles.size()));
        end
        if (error_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
